>>> rtl/core/dfs_pkg.sv
// shared types, constants and helpers of the dielectric fresnel sampler
`default_nettype none
package dfs_pkg;

   localparam int DIR_FRAC_BITS_DEF = 14;
   localparam int WIDE_FRAC         = 30;
   localparam int IOR_FRAC          = 14;
   localparam int CSR_IDX_W         = 4;
   localparam int MID_DEPTH         = 2;
   localparam int OUT_DEPTH         = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_INTERIOR = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_EXTERIOR = CSR_IDX_W'(1);

   localparam logic [15:0] INTERIOR_RST = 16'd24651;
   localparam logic [15:0] EXTERIOR_RST = 16'd16389;
   localparam logic [15:0] ETA_ONE      = 16'd16384;
   localparam logic [19:0] WGT_ONE      = 20'd65536;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic [15:0]        u;
      logic               zero;
      logic               inner;
      logic               same;
      logic [15:0]        e1;
      logic [15:0]        e2;
      logic [15:0]        eta;
      logic [31:0]        etasq;
      logic [19:0]        wgt;
      logic [30:0]        c30;
   } fe_item_type;

   typedef struct packed {
      logic [15:0] dir_out_x;
      logic [15:0] dir_out_y;
      logic [15:0] dir_out_z;
      logic [15:0] eta_ratio;
      logic [19:0] sample_weight;
      logic        refracted;
   } rsp_type;

   // magnitude with a sign applied, saturated to 16 bit two's complement
   function automatic logic [15:0] sat_neg(input logic [31:0] mag, input logic neg);
      logic [15:0] r;
      if (neg) begin
         if (mag > 32'd32768) r = 16'h8000;
         else r = 16'(32'd0 - mag);
      end else begin
         if (mag > 32'd32767) r = 16'h7fff;
         else r = mag[15:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/dfs_fifo.sv
// small register queue between pipeline parts
`default_nettype none
module dfs_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      rdata,
   output logic                  empty
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == CW'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + AW'(1);
      if (do_pop) rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + AW'(1);
      if (do_push && !do_pop) cnt_in = cnt_ff + CW'(1);
      else if (do_pop && !do_push) cnt_in = cnt_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= wdata;
   end

`ifndef SYNTHESIS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(DEPTH)) else $error("queue count beyond depth");
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (cnt_ff == $past(cnt_ff) + CW'(1)))
      else $error("queue count missed a push");
   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      empty |-> (wr_ff == rd_ff)) else $error("empty queue with pointers apart");
`endif
endmodule
`default_nettype wire

>>> rtl/core/dfs_front.sv
// front part: csr file, per-side eta precompute and item classification
`default_nettype none
module dfs_front #(
   parameter int DIR_FRAC_BITS = dfs_pkg::DIR_FRAC_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic signed [15:0]             dir_in_x,
   input  wire logic signed [15:0]             dir_in_y,
   input  wire logic signed [15:0]             dir_in_z,
   input  wire logic [15:0]                    sample_u,
   input  wire logic                           push,
   output logic                                full,
   input  wire logic                           valid,
   output logic                                ready,
   input  wire logic [dfs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [15:0]                    csr_data,
   output logic                                mid_push,
   output dfs_pkg::fe_item_type                mid_item,
   input  wire logic                           mid_full
);
   import dfs_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_SQ   = 2'd2;
   localparam logic [4:0] DIV_LAST = 5'd30;

   logic [15:0] int_ior_ff, int_ior_in, ext_ior_ff, ext_ior_in;
   logic [1:0]  st_ff, st_in;
   logic        side_ff, side_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [15:0] rem_ff, rem_in;
   logic [30:0] q_ff, q_in;
   logic [15:0] eta_ff [2];
   logic [15:0] eta_in [2];
   logic [31:0] etasq_ff [2];
   logic [31:0] etasq_in [2];
   logic [19:0] wgt_ff [2];
   logic [19:0] wgt_in [2];

   logic [15:0] e1s, e2s, eta_c;
   logic [30:0] num;
   logic [16:0] rs;
   logic        ge, busy, cfg_wr;
   logic [31:0] esq;
   logic [32:0] wsum;
   logic [19:0] wgt_c;
   logic [16:0] az, cc;
   logic [63:0] c64;
   logic        ins;

   assign busy   = (st_ff != ST_IDLE);
   assign ready  = 1'b1;
   assign cfg_wr = valid && ready;
   assign full   = mid_full || busy;
   assign mid_push = push && !full;

   // serial restoring divide for eta = round(e1 * 2^14 / e2), one side after the other
   always_comb begin
      e1s   = side_ff ? int_ior_ff : ext_ior_ff;
      e2s   = side_ff ? ext_ior_ff : int_ior_ff;
      num   = {1'b0, e1s, 14'b0} + {16'b0, e2s[15:1]};
      rs    = {rem_ff, num[DIV_LAST - cnt_ff]};
      ge    = (rs >= {1'b0, e2s});
      eta_c = ((e2s == '0) || (q_ff > 31'd65535)) ? 16'hffff : q_ff[15:0];
      esq   = {16'b0, eta_c} * {16'b0, eta_c};
      wsum  = {1'b0, esq} + 33'd2048;
      wgt_c = (wsum[32:12] > 21'hfffff) ? 20'hfffff : wsum[31:12];

      int_ior_in = int_ior_ff;
      ext_ior_in = ext_ior_ff;
      st_in      = st_ff;
      side_in    = side_ff;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      q_in       = q_ff;
      eta_in     = eta_ff;
      etasq_in   = etasq_ff;
      wgt_in     = wgt_ff;

      case (st_ff)
         ST_IDLE: begin
         end
         ST_DIV: begin
            rem_in = ge ? 16'(rs - {1'b0, e2s}) : rs[15:0];
            q_in   = {q_ff[29:0], ge};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == DIV_LAST) st_in = ST_SQ;
         end
         ST_SQ: begin
            eta_in[side_ff]   = eta_c;
            etasq_in[side_ff] = esq;
            wgt_in[side_ff]   = wgt_c;
            if (!side_ff) begin
               side_in = 1'b1;
               st_in   = ST_DIV;
               cnt_in  = '0;
               rem_in  = '0;
               q_in    = '0;
            end else begin
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase

      if (cfg_wr) begin
         case (csr_index)
            CSR_INTERIOR: int_ior_in = csr_data;
            CSR_EXTERIOR: ext_ior_in = csr_data;
            default: begin
            end
         endcase
         st_in   = ST_DIV;
         side_in = 1'b0;
         cnt_in  = '0;
         rem_in  = '0;
         q_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         int_ior_ff <= INTERIOR_RST;
         ext_ior_ff <= EXTERIOR_RST;
         st_ff      <= ST_DIV;
         side_ff    <= 1'b0;
         cnt_ff     <= '0;
         rem_ff     <= '0;
         q_ff       <= '0;
      end else begin
         int_ior_ff <= int_ior_in;
         ext_ior_ff <= ext_ior_in;
         st_ff      <= st_in;
         side_ff    <= side_in;
         cnt_ff     <= cnt_in;
         rem_ff     <= rem_in;
         q_ff       <= q_in;
      end
   end

   always_ff @(posedge clock) begin
      eta_ff   <= eta_in;
      etasq_ff <= etasq_in;
      wgt_ff   <= wgt_in;
   end

   // classify the incoming transaction
   always_comb begin
      ins = dir_in_z[15];
      az  = ins ? (17'd0 - {dir_in_z[15], dir_in_z}) : {1'b0, dir_in_z};
      cc  = ({15'b0, az} > (32'd1 << DIR_FRAC_BITS)) ? 17'(32'd1 << DIR_FRAC_BITS) : az;
      c64 = {47'b0, cc} << (WIDE_FRAC - DIR_FRAC_BITS);
      mid_item.x      = dir_in_x;
      mid_item.y      = dir_in_y;
      mid_item.z      = dir_in_z;
      mid_item.u      = sample_u;
      mid_item.zero   = (dir_in_z == '0);
      mid_item.inner  = ins;
      mid_item.same   = (int_ior_ff == ext_ior_ff);
      mid_item.e1     = ins ? int_ior_ff : ext_ior_ff;
      mid_item.e2     = ins ? ext_ior_ff : int_ior_ff;
      mid_item.eta    = eta_ff[ins];
      mid_item.etasq  = etasq_ff[ins];
      mid_item.wgt    = wgt_ff[ins];
      mid_item.c30    = c64[30:0];
   end

`ifndef SYNTHESIS
   a_busy_full: assert property (@(posedge clock) disable iff (reset)
      busy |-> full) else $error("item taken while eta is recomputed");
   a_cfg_restart: assert property (@(posedge clock) disable iff (reset)
      cfg_wr |=> (st_ff == ST_DIV && cnt_ff == '0 && !side_ff))
      else $error("csr write did not restart eta precompute");
`endif
endmodule
`default_nettype wire

>>> rtl/core/dfs_back.sv
// back part: cosine, sqrt, fresnel dividers and result selection, one item a cycle while the result queue is not full
`default_nettype none
module dfs_back #(
   parameter int DIR_FRAC_BITS = dfs_pkg::DIR_FRAC_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  mid_empty,
   input  wire dfs_pkg::fe_item_type  mid_item,
   output logic                       mid_pop,
   input  wire logic                  out_full,
   output logic                       out_push,
   output dfs_pkg::rsp_type           out_data
);
   import dfs_pkg::*;

   localparam int SQ_N    = 31;
   localparam int DV_N    = 31;
   localparam int ST_SQ0  = 3;
   localparam int ST_PROD = ST_SQ0 + SQ_N + 1;
   localparam int ST_DS   = ST_PROD + 1;
   localparam int ST_SQR  = ST_DS + DV_N + 1;
   localparam int LAT     = ST_SQR + 1;
   localparam int MZ_SH   = WIDE_FRAC - DIR_FRAC_BITS;

   typedef struct packed {
      fe_item_type fe;
      logic [32:0] mxp;
      logic [32:0] myp;
      logic        tir;
      logic [30:0] ct30;
      logic        fz1;
      logic        fz2;
   } bk_item_type;

   logic              en;
   logic [LAT-1:0]    vld_ff, vld_in;
   bk_item_type       itm_ff [LAT];
   bk_item_type       itm_in [LAT];
   logic [61:0]       c30sq_ff, c30sq_in;
   logic [30:0]       s2_ff, s2_in;
   logic [62:0]       st2p_ff, st2p_in;
   logic [61:0]       rad_ff [SQ_N+1];
   logic [61:0]       rad_in [SQ_N+1];
   logic [32:0]       srem_ff [SQ_N+1];
   logic [32:0]       srem_in [SQ_N+1];
   logic [30:0]       root_ff [SQ_N+1];
   logic [30:0]       root_in [SQ_N+1];
   logic [31:0]       pa_ff, pa_in, pb_ff, pb_in, pp_ff, pp_in, pq_ff, pq_in;
   logic [32:0]       dr1_ff [DV_N+1];
   logic [32:0]       dr1_in [DV_N+1];
   logic [32:0]       ds1_ff [DV_N+1];
   logic [32:0]       ds1_in [DV_N+1];
   logic [30:0]       dq1_ff [DV_N+1];
   logic [30:0]       dq1_in [DV_N+1];
   logic [32:0]       dr2_ff [DV_N+1];
   logic [32:0]       dr2_in [DV_N+1];
   logic [32:0]       ds2_ff [DV_N+1];
   logic [32:0]       ds2_in [DV_N+1];
   logic [30:0]       dq2_ff [DV_N+1];
   logic [30:0]       dq2_in [DV_N+1];
   logic [16:0]       t1_ff, t1_in, t2_ff, t2_in;

   logic [16:0]       ax0, ay0;
   logic [60:0]       s2d;
   logic [34:0]       st2;
   logic              tir_c;
   logic [30:0]       w_c;
   logic [34:0]       sq_r2 [SQ_N];
   logic [34:0]       sq_tr [SQ_N];
   logic              sq_ge [SQ_N];
   logic [33:0]       d1_r2 [DV_N];
   logic [33:0]       d2_r2 [DV_N];
   logic              d1_ge [DV_N];
   logic              d2_ge [DV_N];
   logic [46:0]       ma, mb, mp, mq;
   logic [31:0]       dd1, dd2;
   logic [32:0]       ss1, ss2;
   logic [61:0]       sqp1, sqp2;

   bk_item_type       fin;
   logic [17:0]       fsum;
   logic [16:0]       frc;
   logic              refr;
   logic [32:0]       mxr, myr, mzr;
   logic [16:0]       axf, ayf;

   assign en       = !out_full;
   assign mid_pop  = en && !mid_empty;
   assign out_push = en && vld_ff[LAT-1];
   assign vld_in   = {vld_ff[LAT-2:0], !mid_empty};

   always_comb begin
      // entry stage: squared cosine and the refracted x, y products
      ax0 = mid_item.x[15] ? (17'd0 - {mid_item.x[15], mid_item.x}) : {1'b0, mid_item.x};
      ay0 = mid_item.y[15] ? (17'd0 - {mid_item.y[15], mid_item.y}) : {1'b0, mid_item.y};
      itm_in[0]     = '0;
      itm_in[0].fe  = mid_item;
      itm_in[0].mxp = {17'b0, mid_item.eta} * {16'b0, ax0};
      itm_in[0].myp = {17'b0, mid_item.eta} * {16'b0, ay0};
      c30sq_in      = {31'b0, mid_item.c30} * {31'b0, mid_item.c30};
      for (int k = 1; k < LAT; k++) itm_in[k] = itm_ff[k-1];

      // sin^2 of incidence, then of transmission
      s2d     = (61'd1 << 60) - c30sq_ff[60:0];
      s2_in   = s2d[60:30];
      st2p_in = {31'b0, itm_ff[1].fe.etasq} * {32'b0, s2_ff};
      st2     = st2p_ff[62:28];
      tir_c   = (st2 > 35'h0_4000_0000);
      w_c     = tir_c ? '0 : 31'(35'h0_4000_0000 - st2);
      itm_in[ST_SQ0].tir = tir_c;
      rad_in[0]  = {1'b0, w_c, 30'b0};
      srem_in[0] = '0;
      root_in[0] = '0;

      // digit-by-digit square root, one result bit per stage
      for (int j = 0; j < SQ_N; j++) begin
         sq_r2[j]     = {srem_ff[j], rad_ff[j][61:60]};
         sq_tr[j]     = {2'b0, root_ff[j], 2'b01};
         sq_ge[j]     = (sq_r2[j] >= sq_tr[j]);
         srem_in[j+1] = sq_ge[j] ? 33'(sq_r2[j] - sq_tr[j]) : sq_r2[j][32:0];
         root_in[j+1] = {root_ff[j][29:0], sq_ge[j]};
         rad_in[j+1]  = {rad_ff[j][59:0], 2'b00};
      end

      itm_in[ST_PROD].ct30 = root_ff[SQ_N];
      ma    = {15'b0, itm_ff[ST_PROD-1].fe.e1} * {16'b0, itm_ff[ST_PROD-1].fe.c30};
      mb    = {15'b0, itm_ff[ST_PROD-1].fe.e2} * {16'b0, root_ff[SQ_N]};
      mp    = {15'b0, itm_ff[ST_PROD-1].fe.e2} * {16'b0, itm_ff[ST_PROD-1].fe.c30};
      mq    = {15'b0, itm_ff[ST_PROD-1].fe.e1} * {16'b0, root_ff[SQ_N]};
      pa_in = ma[45:14];
      pb_in = mb[45:14];
      pp_in = mp[45:14];
      pq_in = mq[45:14];

      dd1 = (pa_ff > pb_ff) ? pa_ff - pb_ff : pb_ff - pa_ff;
      dd2 = (pp_ff > pq_ff) ? pp_ff - pq_ff : pq_ff - pp_ff;
      ss1 = {1'b0, pa_ff} + {1'b0, pb_ff};
      ss2 = {1'b0, pp_ff} + {1'b0, pq_ff};
      itm_in[ST_DS].fz1 = (ss1 == '0);
      itm_in[ST_DS].fz2 = (ss2 == '0);
      dr1_in[0] = {1'b0, dd1};
      ds1_in[0] = ss1;
      dq1_in[0] = '0;
      dr2_in[0] = {1'b0, dd2};
      ds2_in[0] = ss2;
      dq2_in[0] = '0;

      // restoring dividers for |a-b|/(a+b), top quotient bit first
      for (int k = 0; k < DV_N; k++) begin
         d1_r2[k] = (k == 0) ? {1'b0, dr1_ff[k]} : {dr1_ff[k], 1'b0};
         d2_r2[k] = (k == 0) ? {1'b0, dr2_ff[k]} : {dr2_ff[k], 1'b0};
         d1_ge[k] = (d1_r2[k] >= {1'b0, ds1_ff[k]});
         d2_ge[k] = (d2_r2[k] >= {1'b0, ds2_ff[k]});
         dr1_in[k+1] = d1_ge[k] ? 33'(d1_r2[k] - {1'b0, ds1_ff[k]}) : d1_r2[k][32:0];
         dr2_in[k+1] = d2_ge[k] ? 33'(d2_r2[k] - {1'b0, ds2_ff[k]}) : d2_r2[k][32:0];
         ds1_in[k+1] = ds1_ff[k];
         ds2_in[k+1] = ds2_ff[k];
         dq1_in[k+1] = {dq1_ff[k][29:0], d1_ge[k]};
         dq2_in[k+1] = {dq2_ff[k][29:0], d2_ge[k]};
      end

      sqp1  = {31'b0, dq1_ff[DV_N]} * {31'b0, dq1_ff[DV_N]};
      sqp2  = {31'b0, dq2_ff[DV_N]} * {31'b0, dq2_ff[DV_N]};
      t1_in = itm_ff[ST_SQR-1].fz1 ? '0 : sqp1[60:44];
      t2_in = itm_ff[ST_SQR-1].fz2 ? '0 : sqp2[60:44];
   end

   // reflectance and final selection into the result queue
   always_comb begin
      fin  = itm_ff[LAT-1];
      fsum = {1'b0, t1_ff} + {1'b0, t2_ff};
      if (fin.fe.same) frc = '0;
      else if (fin.tir) frc = 17'h10000;
      else frc = fsum[17:1];
      refr = ({1'b0, fin.fe.u} > frc);
      mxr  = (fin.mxp + 33'd8192) >> IOR_FRAC;
      myr  = (fin.myp + 33'd8192) >> IOR_FRAC;
      mzr  = ({1'b0, fin.ct30, 1'b0} + (33'd1 << MZ_SH)) >> (MZ_SH + 1);
      axf  = fin.fe.x[15] ? (17'd0 - {fin.fe.x[15], fin.fe.x}) : {1'b0, fin.fe.x};
      ayf  = fin.fe.y[15] ? (17'd0 - {fin.fe.y[15], fin.fe.y}) : {1'b0, fin.fe.y};
      out_data = '0;
      if (fin.fe.zero) begin
         out_data = '0;
      end else if (refr) begin
         out_data.dir_out_x     = sat_neg(mxr[31:0], !fin.fe.x[15]);
         out_data.dir_out_y     = sat_neg(myr[31:0], !fin.fe.y[15]);
         out_data.dir_out_z     = sat_neg(mzr[31:0], !fin.fe.inner);
         out_data.eta_ratio     = fin.fe.eta;
         out_data.sample_weight = (mzr == '0) ? '0 : fin.fe.wgt;
         out_data.refracted     = 1'b1;
      end else begin
         out_data.dir_out_x     = sat_neg({15'b0, axf}, !fin.fe.x[15]);
         out_data.dir_out_y     = sat_neg({15'b0, ayf}, !fin.fe.y[15]);
         out_data.dir_out_z     = fin.fe.z;
         out_data.eta_ratio     = ETA_ONE;
         out_data.sample_weight = WGT_ONE;
         out_data.refracted     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (en) vld_ff <= vld_in;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         itm_ff   <= itm_in;
         c30sq_ff <= c30sq_in;
         s2_ff    <= s2_in;
         st2p_ff  <= st2p_in;
         rad_ff   <= rad_in;
         srem_ff  <= srem_in;
         root_ff  <= root_in;
         pa_ff    <= pa_in;
         pb_ff    <= pb_in;
         pp_ff    <= pp_in;
         pq_ff    <= pq_in;
         dr1_ff   <= dr1_in;
         ds1_ff   <= ds1_in;
         dq1_ff   <= dq1_in;
         dr2_ff   <= dr2_in;
         ds2_ff   <= ds2_in;
         dq2_ff   <= dq2_in;
         t1_ff    <= t1_in;
         t2_ff    <= t2_in;
      end
   end

`ifndef SYNTHESIS
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff)) else $error("pipeline moved while stalled");
   a_sqrt_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_PROD-1] |-> (root_ff[SQ_N] <= 31'h4000_0000))
      else $error("transmitted cosine above one");
   a_div_range: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[ST_SQR-1] && !itm_ff[ST_SQR-1].fz1) |-> (dq1_ff[DV_N] <= 31'h4000_0000))
      else $error("fresnel ratio above one");
`endif
endmodule
`default_nettype wire

>>> rtl/core/dielectric_fresnel_sampler_core.sv
// top level of the smooth dielectric fresnel sampler
//
//  channel   ports                         transfer
//  request   push / full, req_*            push && !full
//  response  empty / pop, rsp_*            pop && !empty
//  csr       valid / ready, csr_*          valid && ready
//
// one item per cycle sustained while the result queue drains and no eta divide runs; a request
// passes the middle queue and then 69 back pipeline stages (31 sqrt and 31 divider
// stages make up most of them); the result shows on rsp_* at the edge it enters an
// empty result queue. after reset and after every csr write the front runs the
// serial eta divide for both sides, with full held high; csr writes are always taken.
// a full result queue freezes the back pipeline; the request side stalls once the
// two-entry middle queue fills or while the eta divide runs.
`default_nettype none
module dielectric_fresnel_sampler_core #(
   parameter int DIR_FRAC_BITS = dfs_pkg::DIR_FRAC_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic signed [15:0]            req_dir_in_x,
   input  wire logic signed [15:0]            req_dir_in_y,
   input  wire logic signed [15:0]            req_dir_in_z,
   input  wire logic [15:0]                   req_sample_u,
   input  wire logic                          push,
   output logic                               full,
   output logic signed [15:0]                 rsp_dir_out_x,
   output logic signed [15:0]                 rsp_dir_out_y,
   output logic signed [15:0]                 rsp_dir_out_z,
   output logic [15:0]                        rsp_eta_ratio,
   output logic [19:0]                        rsp_sample_weight,
   output logic                               rsp_refracted,
   output logic                               empty,
   input  wire logic                          pop,
   input  wire logic                          valid,
   output logic                               ready,
   input  wire logic [dfs_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [15:0]                   csr_data
);
   import dfs_pkg::*;

   localparam int FE_W  = $bits(fe_item_type);
   localparam int RSP_W = $bits(rsp_type);

   fe_item_type fe_item, mid_head;
   rsp_type     bk_rsp, out_rsp;
   logic        mid_push, mid_full, mid_pop, mid_empty;
   logic        out_push, out_full;
   logic [FE_W-1:0]  mid_rdata;
   logic [RSP_W-1:0] out_rdata;

   dfs_front #(.DIR_FRAC_BITS(DIR_FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .dir_in_x  (req_dir_in_x),
      .dir_in_y  (req_dir_in_y),
      .dir_in_z  (req_dir_in_z),
      .sample_u  (req_sample_u),
      .push      (push),
      .full      (full),
      .valid     (valid),
      .ready     (ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .mid_push  (mid_push),
      .mid_item  (fe_item),
      .mid_full  (mid_full)
   );

   dfs_fifo #(.WIDTH(FE_W), .DEPTH(MID_DEPTH)) u_mid_q (
      .clock (clock),
      .reset (reset),
      .push  (mid_push),
      .wdata (fe_item),
      .full  (mid_full),
      .pop   (mid_pop),
      .rdata (mid_rdata),
      .empty (mid_empty)
   );

   assign mid_head = fe_item_type'(mid_rdata);

   dfs_back #(.DIR_FRAC_BITS(DIR_FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .mid_item  (mid_head),
      .mid_pop   (mid_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_data  (bk_rsp)
   );

   dfs_fifo #(.WIDTH(RSP_W), .DEPTH(OUT_DEPTH)) u_out_q (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (bk_rsp),
      .full  (out_full),
      .pop   (pop),
      .rdata (out_rdata),
      .empty (empty)
   );

   assign out_rsp           = rsp_type'(out_rdata);
   assign rsp_dir_out_x     = out_rsp.dir_out_x;
   assign rsp_dir_out_y     = out_rsp.dir_out_y;
   assign rsp_dir_out_z     = out_rsp.dir_out_z;
   assign rsp_eta_ratio     = out_rsp.eta_ratio;
   assign rsp_sample_weight = out_rsp.sample_weight;
   assign rsp_refracted     = out_rsp.refracted;

`ifndef SYNTHESIS
   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_refracted) |-> (rsp_eta_ratio != '0 || rsp_sample_weight == '0))
      else $error("transmitted transaction with zero eta and a weight");
   a_reflect_eta: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_refracted && rsp_sample_weight != '0) |-> (rsp_eta_ratio == ETA_ONE))
      else $error("reflected transaction without unit eta");
   a_no_pop_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(out_rdata)))
      else $error("waiting result changed before it was taken");
`endif
endmodule
`default_nettype wire

>>> test/testbench.sv
// self-checking testbench of the dielectric fresnel sampler core
`timescale 1ns / 1ps
module testbench;
   import dfs_pkg::*;

   typedef struct {
      logic signed [15:0] x, y, z;
      logic [15:0]        u;
      bit                 typed;
      rsp_type            res;
   } scatter_row_type;

   localparam int ITEMS_PER_PHASE = 275;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int DRAIN_CYCLES    = 100;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic signed [15:0] req_dir_in_x = '0, req_dir_in_y = '0, req_dir_in_z = '0;
   logic [15:0] req_sample_u = '0;
   logic push = 1'b0, pop = 1'b0, valid = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_INTERIOR;
   logic [15:0] csr_data = '0;
   logic full, empty, ready;
   logic signed [15:0] rsp_dir_out_x, rsp_dir_out_y, rsp_dir_out_z;
   logic [15:0] rsp_eta_ratio;
   logic [19:0] rsp_sample_weight;
   logic rsp_refracted;

   dielectric_fresnel_sampler_core dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   logic [15:0] interior_ior = INTERIOR_RST, exterior_ior = EXTERIOR_RST;
   rsp_type scatter_q[$];
   bit      cur_typed = 1'b0;
   rsp_type cur_res;
   int      n_sent = 0, n_errors = 0, n_mismatch = 0, cycles = 0;
   bit      hold_done = 1'b0;

   function automatic longint unsigned isqrt(input longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic logic [15:0] clip16(input longint v);
      if (v > 32767) return 16'h7fff;
      if (v < -32768) return 16'h8000;
      return v[15:0];
   endfunction

   // squared fresnel term |p-q|/(p+q), Q.16
   function automatic longint unsigned fresnel_sq(input longint unsigned p, q);
      longint unsigned d, s, r;
      d = p > q ? p - q : q - p;
      s = p + q;
      if (s == 0) return 0;
      r = (d << 30) / s;
      return (r * r) >> 44;
   endfunction

   function automatic rsp_type scatter(input logic signed [15:0] x, y, z,
                                       input logic [15:0] u);
      rsp_type o;
      bit inner;
      longint unsigned e1, e2, eta, c, c30, s2, st2, ct30, fr, mx, my, mz, w;
      longint ax, ay;
      o = '0;
      if (z == 0) return o;
      inner = z < 0;
      e1 = inner ? interior_ior : exterior_ior;
      e2 = inner ? exterior_ior : interior_ior;
      if (e2 == 0) eta = 65535;
      else begin
         eta = ((e1 << 14) + (e2 >> 1)) / e2;
         if (eta > 65535) eta = 65535;
      end
      c = inner ? -longint'(z) : longint'(z);
      if (c > 16384) c = 16384;
      c30 = c << 16;
      s2 = ((64'd1 << 60) - c30 * c30) >> 30;
      st2 = ((eta * eta) * s2) >> 28;
      ct30 = st2 > (64'd1 << 30) ? 0 : isqrt(((64'd1 << 30) - st2) << 30);
      if (e1 == e2) fr = 0;
      else if (st2 > (64'd1 << 30)) fr = 65536;
      else fr = (fresnel_sq((e1 * c30) >> 14, (e2 * ct30) >> 14)
                 + fresnel_sq((e2 * c30) >> 14, (e1 * ct30) >> 14)) >> 1;
      ax = x < 0 ? -longint'(x) : longint'(x);
      ay = y < 0 ? -longint'(y) : longint'(y);
      if (u > fr) begin
         mx = (eta * ax + 8192) >> 14;
         my = (eta * ay + 8192) >> 14;
         mz = (ct30 + 32768) >> 16;
         o.dir_out_x = clip16(x < 0 ? longint'(mx) : -longint'(mx));
         o.dir_out_y = clip16(y < 0 ? longint'(my) : -longint'(my));
         o.dir_out_z = clip16(inner ? longint'(mz) : -longint'(mz));
         o.eta_ratio = eta[15:0];
         w = (eta * eta + 2048) >> 12;
         if (w > 20'hfffff) w = 20'hfffff;
         o.sample_weight = mz == 0 ? 20'd0 : w[19:0];
         o.refracted = 1'b1;
      end else begin
         o.dir_out_x = clip16(-longint'(x));
         o.dir_out_y = clip16(-longint'(y));
         o.dir_out_z = z;
         o.eta_ratio = ETA_ONE;
         o.sample_weight = WGT_ONE;
         o.refracted = 1'b0;
      end
      return o;
   endfunction

   // transaction monitor on the request and response channels
   always @(posedge clock) begin
      rsp_type want, got;
      cycles <= cycles + 1;
      if (!reset && push && !full) begin
         scatter_q.push_back(cur_typed ? cur_res
                             : scatter(req_dir_in_x, req_dir_in_y, req_dir_in_z, req_sample_u));
         n_sent++;
      end
      if (!reset && pop && !empty) begin
         got = '{rsp_dir_out_x, rsp_dir_out_y, rsp_dir_out_z, rsp_eta_ratio,
                 rsp_sample_weight, rsp_refracted};
         if (scatter_q.size() == 0) begin
            n_errors++;
            $display("unexpected result %p", got);
         end else begin
            want = scatter_q.pop_front();
            if (got.dir_out_x !== want.dir_out_x || got.dir_out_y !== want.dir_out_y ||
                got.dir_out_z !== want.dir_out_z || got.eta_ratio !== want.eta_ratio ||
                got.sample_weight !== want.sample_weight ||
                got.refracted !== want.refracted) begin
               n_errors++;
               n_mismatch++;
               if (n_mismatch <= 10)
                  $display("mismatch: expected %p actual %p", want, got);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycles >= CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   function automatic bit quiet_window();
      return cycles > 3000 && cycles < 5000;
   endfunction

   // result side: random stalls plus one long hold-off
   initial begin
      int hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (!hold_done && n_sent >= 600) begin
            hold_done = 1'b1;
            hold = 400;
         end
         if (hold > 0) begin
            hold--;
            pop <= 1'b0;
         end else begin
            pop <= quiet_window() || $urandom_range(0, 99) >= 8;
         end
      end
   end

   task automatic send(input scatter_row_type r);
      @(negedge clock);
      while (!quiet_window() && $urandom_range(0, 99) < 8) begin
         push <= 1'b0;
         @(negedge clock);
      end
      req_dir_in_x <= r.x;
      req_dir_in_y <= r.y;
      req_dir_in_z <= r.z;
      req_sample_u <= r.u;
      cur_typed <= r.typed;
      cur_res <= r.res;
      push <= 1'b1;
      do @(posedge clock); while (full);
   endtask

   task automatic settle();
      @(negedge clock);
      push <= 1'b0;
      wait (scatter_q.size() == 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] data);
      @(negedge clock);
      valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!ready);
      if (idx == CSR_INTERIOR) interior_ior = data;
      else exterior_ior = data;
      @(negedge clock);
      valid <= 1'b0;
   endtask

   function automatic logic signed [15:0] rand_dir();
      case ($urandom_range(0, 9))
         0: return 16'sd16384;
         1: return -16'sd16384;
         default: return 16'($urandom_range(0, 32768)) - 16'sd16384;
      endcase
   endfunction

   scatter_row_type directed[] = '{
      '{16'sd100, 16'sd200, 16'sd0, 16'hffff, 1, '0},
      '{-16'sd16384, 16'sd16384, 16'sd0, 16'h0000, 1, '0},
      '{16'sd16384, -16'sd16384, 16'sd16384, 16'h0000, 1,
        '{16'hc000, 16'h4000, 16'h4000, ETA_ONE, WGT_ONE, 1'b0}},
      '{-16'sd16384, 16'sd0, -16'sd16384, 16'h0000, 1,
        '{16'h4000, 16'h0000, 16'hc000, ETA_ONE, WGT_ONE, 1'b0}},
      '{16'sd0, 16'sd16383, 16'sd100, 16'h0000, 1,
        '{16'h0000, 16'hc001, 16'h0064, ETA_ONE, WGT_ONE, 1'b0}},
      '{16'sd0, 16'sd0, 16'sd16384, 16'hffff, 0, '0},
      '{16'sd0, 16'sd0, -16'sd16384, 16'hffff, 0, '0},
      '{16'sd16384, 16'sd16384, 16'sd1, 16'hffff, 0, '0},
      '{-16'sd16384, -16'sd16384, -16'sd1, 16'hffff, 0, '0},
      '{16'sd12000, 16'sd0, -16'sd11000, 16'd40000, 0, '0},
      '{16'sd5000, -16'sd7000, 16'sd16384, 16'hffff, 0, '0},
      '{-16'sd1, 16'sd1, -16'sd5000, 16'd30000, 0, '0},
      '{16'sd8, 16'sd8, 16'sd8, 16'hffff, 0, '0}
   };

   logic [15:0] ior_set[6][2] = '{
      '{16'd65535, 16'd16384}, '{16'd16384, 16'd65535}, '{16'd20000, 16'd20000},
      '{16'd16384, 16'd16384}, '{16'd30000, 16'd50000}, '{INTERIOR_RST, EXTERIOR_RST}
   };

   initial begin
      scatter_row_type r;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed[i]) send(directed[i]);
      for (int p = 0; p < 6; p++) begin
         settle();
         if (p == 4) begin
            ior_set[p][0] = 16'($urandom_range(16384, 65535));
            ior_set[p][1] = 16'($urandom_range(16384, 65535));
         end
         csr_write(CSR_INTERIOR, ior_set[p][0]);
         csr_write(CSR_EXTERIOR, ior_set[p][1]);
         repeat (ITEMS_PER_PHASE) begin
            r.x = rand_dir();
            r.y = rand_dir();
            r.z = $urandom_range(0, 19) == 0 ? 16'sd0 : rand_dir();
            r.u = 16'($urandom);
            r.typed = 1'b0;
            r.res = '0;
            send(r);
         end
      end
      settle();
      if (n_errors == 0 && scatter_q.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
